// File: design/timer_pool_one_shot_periodic_core_macros.svh
// ---------------------------------------------------------------------------
// Timer pool assertion macros
// Shared concurrent assertion forms for the timer pool modules.
// ---------------------------------------------------------------------------
`ifndef TIMER_POOL_ONE_SHOT_PERIODIC_CORE_MACROS_SVH
`define TIMER_POOL_ONE_SHOT_PERIODIC_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TPOOL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer pool assertion failed");
`define TPOOL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer pool assertion failed");
`else
`define TPOOL_ASSERT_IMPL(label, ante, cons)
`define TPOOL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/tpool_pkg.sv
// ---------------------------------------------------------------------------
// Timer pool package
// Command and result types, step codes and constants of the timer pool.
// ---------------------------------------------------------------------------
package tpool_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int MAX_OUT   = 16;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_CREATE   = 3'd1,
		ACT_DESTROY  = 3'd2,
		ACT_START    = 3'd3,
		ACT_STOP     = 3'd4,
		ACT_SET_TO   = 3'd5,
		ACT_SET_TYPE = 3'd6,
		ACT_QUERY    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_TICK_RD,
		OP_TICK_EV,
		OP_TICK_END,
		OP_CREATE,
		OP_EXEC,
		OP_QRY_EL,
		OP_QRY_OUT
	} op_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  handle;
		logic [31:0] timeout;
		logic        periodic;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  handle_out;
		logic        fired;
		logic        running;
		logic        expired;
		logic [31:0] elapsed;
		logic [31:0] remaining;
		logic [31:0] now;
		logic        last;
	} result_t;

	typedef struct packed {
		logic accept;
		op_t  op;
	} ctl_t;

	typedef struct packed {
		logic sweep_last;
		logic scan_done;
		logic query_ok;
	} sts_t;

endpackage

// File: design/tpool_ram.sv
// ---------------------------------------------------------------------------
// Timer pool RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module tpool_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = tpool_pkg::SLOTS_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/tpool_ctrl.sv
// ---------------------------------------------------------------------------
// Timer pool controller
// Sequences each command transaction through the datapath steps.
// ---------------------------------------------------------------------------
`include "timer_pool_one_shot_periodic_core_macros.svh"

module tpool_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tpool_pkg::action_t action,
	input  tpool_pkg::sts_t   sts,
	output tpool_pkg::ctl_t   ctl,
	output logic              busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK_RD,
		S_TICK_EV,
		S_TICK_END,
		S_CREATE,
		S_EXEC,
		S_QRY_EL,
		S_QRY_OUT
	} state_t;

	state_t         state_q;
	tpool_pkg::op_t op_q;
	logic           busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= tpool_pkg::OP_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						case (action)
							tpool_pkg::ACT_TICK: begin
								state_q <= S_TICK_RD;
								op_q    <= tpool_pkg::OP_TICK_RD;
							end
							tpool_pkg::ACT_CREATE: begin
								state_q <= S_CREATE;
								op_q    <= tpool_pkg::OP_CREATE;
							end
							default: begin
								state_q <= S_EXEC;
								op_q    <= tpool_pkg::OP_EXEC;
							end
						endcase
					end
				end
				S_TICK_RD: begin
					state_q <= S_TICK_EV;
					op_q    <= tpool_pkg::OP_TICK_EV;
				end
				S_TICK_EV: begin
					if (sts.sweep_last) begin
						state_q <= S_TICK_END;
						op_q    <= tpool_pkg::OP_TICK_END;
					end
				end
				S_CREATE: begin
					if (sts.scan_done) begin
						state_q <= S_IDLE;
						op_q    <= tpool_pkg::OP_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_EXEC: begin
					if (sts.query_ok) begin
						state_q <= S_QRY_EL;
						op_q    <= tpool_pkg::OP_QRY_EL;
					end else begin
						state_q <= S_IDLE;
						op_q    <= tpool_pkg::OP_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_QRY_EL: begin
					state_q <= S_QRY_OUT;
					op_q    <= tpool_pkg::OP_QRY_OUT;
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= tpool_pkg::OP_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign ctl.accept = start && !busy_q;
	assign ctl.op     = op_q;

	`TPOOL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`TPOOL_ASSERT_NEXT(a_sweep_end, state_q == S_TICK_EV && sts.sweep_last, state_q == S_TICK_END)
	`TPOOL_ASSERT_NEXT(a_scan_hold, state_q == S_CREATE && !sts.scan_done, state_q == S_CREATE)

endmodule

// File: design/tpool_dp.sv
// ---------------------------------------------------------------------------
// Timer pool datapath
// Tick counter, slot flags, slot RAMs, sweep arithmetic and result register.
// ---------------------------------------------------------------------------
`include "timer_pool_one_shot_periodic_core_macros.svh"

module tpool_dp #(
	parameter int SLOTS = tpool_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tpool_pkg::cmd_t    cmd,
	input  tpool_pkg::ctl_t    ctl,
	output tpool_pkg::sts_t    sts,
	output tpool_pkg::result_t result,
	output logic               strobe
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(tpool_pkg::MAX_OUT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [NW-1:0] MAX_N    = NW'(tpool_pkg::MAX_OUT);

	tpool_pkg::cmd_t    cmd_q;
	tpool_pkg::result_t res_q;
	tpool_pkg::result_t res_d;
	logic               strobe_q;
	logic               emit;
	logic [31:0]        now_q;
	logic [SLOTS-1:0]   used_q;
	logic [SLOTS-1:0]   run_q;
	logic [SLOTS-1:0]   per_q;
	logic [IW-1:0]      idx_q;
	logic [NW-1:0]      n_q;
	logic               pend_v_q;
	logic [3:0]         pend_h_q;
	logic [31:0]        el_q;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic          to_we;
	logic          st_we;
	logic          el_we;
	logic [31:0]   to_wd;
	logic [31:0]   st_wd;
	logic [31:0]   el_wd;
	logic [31:0]   to_rd;
	logic [31:0]   st_rd;
	logic [31:0]   el_rd;

	logic [IW-1:0] hidx;
	logic          hvalid;
	logic          to_zero;
	logic          exec_ok;
	logic          alloc;
	logic          slot_act;
	logic [31:0]   sweep_el;
	logic          fire;
	logic          restart;
	logic          room;
	logic [31:0]   qry_el;
	logic [32:0]   qdiff;
	logic          q_ge;

	assign hidx     = IW'(cmd_q.handle);
	assign hvalid   = (32'(cmd_q.handle) < 32'(SLOTS)) && used_q[hidx];
	assign to_zero  = (cmd_q.timeout == '0);
	assign exec_ok  = hvalid && !(cmd_q.action == tpool_pkg::ACT_SET_TO && to_zero);
	assign alloc    = !used_q[idx_q];
	assign slot_act = used_q[idx_q] && run_q[idx_q];
	assign sweep_el = now_q - st_rd;
	assign fire     = slot_act && (sweep_el >= to_rd);
	assign restart  = fire && per_q[idx_q];
	assign room     = (n_q < MAX_N);
	assign qry_el   = run_q[hidx] ? (now_q - st_rd) : el_rd;
	assign qdiff    = {1'b0, to_rd} - {1'b0, el_q};
	assign q_ge     = qdiff[32] || (qdiff[31:0] == '0);

	assign sts.sweep_last = (idx_q == LAST_IDX);
	assign sts.scan_done  = to_zero || alloc || (idx_q == LAST_IDX);
	assign sts.query_ok   = (cmd_q.action == tpool_pkg::ACT_QUERY) && hvalid;

	always_comb begin
		case (ctl.op)
			tpool_pkg::OP_TICK_EV: rd_addr = idx_q + 1'b1;
			tpool_pkg::OP_EXEC:    rd_addr = hidx;
			tpool_pkg::OP_QRY_EL:  rd_addr = hidx;
			tpool_pkg::OP_QRY_OUT: rd_addr = hidx;
			default:               rd_addr = idx_q;
		endcase
	end

	always_comb begin
		wr_addr = idx_q;
		to_we   = 1'b0;
		st_we   = 1'b0;
		el_we   = 1'b0;
		to_wd   = cmd_q.timeout;
		st_wd   = now_q;
		el_wd   = '0;
		case (ctl.op)
			tpool_pkg::OP_TICK_EV: begin
				if (slot_act) begin
					st_we = restart;
					el_we = 1'b1;
					el_wd = restart ? 32'd0 : sweep_el;
				end
			end
			tpool_pkg::OP_CREATE: begin
				if (!to_zero && alloc) begin
					to_we = 1'b1;
					st_we = 1'b1;
					el_we = 1'b1;
					st_wd = '0;
				end
			end
			tpool_pkg::OP_EXEC: begin
				wr_addr = hidx;
				if (exec_ok && cmd_q.action == tpool_pkg::ACT_START) begin
					st_we = 1'b1;
					el_we = 1'b1;
				end
				if (exec_ok && cmd_q.action == tpool_pkg::ACT_SET_TO) begin
					to_we = 1'b1;
				end
			end
			tpool_pkg::OP_QRY_EL: begin
				wr_addr = hidx;
				el_we   = run_q[hidx];
				el_wd   = qry_el;
			end
			default: begin
			end
		endcase
	end

	tpool_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_to_ram (
		.clk   (clk),
		.we    (to_we),
		.waddr (wr_addr),
		.wdata (to_wd),
		.raddr (rd_addr),
		.rdata (to_rd)
	);

	tpool_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (wr_addr),
		.wdata (st_wd),
		.raddr (rd_addr),
		.rdata (st_rd)
	);

	tpool_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_el_ram (
		.clk   (clk),
		.we    (el_we),
		.waddr (wr_addr),
		.wdata (el_wd),
		.raddr (rd_addr),
		.rdata (el_rd)
	);

	always_comb begin
		emit             = 1'b0;
		res_d            = '0;
		res_d.status     = tpool_pkg::ST_OK;
		res_d.now        = now_q;
		res_d.last       = 1'b1;
		case (ctl.op)
			tpool_pkg::OP_TICK_EV: begin
				emit             = fire && room && pend_v_q;
				res_d.handle_out = pend_h_q;
				res_d.fired      = 1'b1;
				res_d.last       = 1'b0;
			end
			tpool_pkg::OP_TICK_END: begin
				emit = 1'b1;
				if (pend_v_q) begin
					res_d.handle_out = pend_h_q;
					res_d.fired      = 1'b1;
				end
			end
			tpool_pkg::OP_CREATE: begin
				if (to_zero) begin
					emit         = 1'b1;
					res_d.status = tpool_pkg::ST_INVALID;
				end else if (alloc) begin
					emit             = 1'b1;
					res_d.handle_out = 4'(idx_q);
				end else if (idx_q == LAST_IDX) begin
					emit         = 1'b1;
					res_d.status = tpool_pkg::ST_FULL;
				end
			end
			tpool_pkg::OP_EXEC: begin
				emit             = !sts.query_ok;
				res_d.handle_out = cmd_q.handle;
				res_d.status     = exec_ok ? tpool_pkg::ST_OK : tpool_pkg::ST_INVALID;
			end
			tpool_pkg::OP_QRY_OUT: begin
				emit             = 1'b1;
				res_d.handle_out = cmd_q.handle;
				res_d.running    = run_q[hidx];
				res_d.expired    = run_q[hidx] && q_ge;
				res_d.elapsed    = el_q;
				res_d.remaining  = q_ge ? 32'd0 : qdiff[31:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			used_q   <= '0;
			run_q    <= '0;
			per_q    <= '0;
			idx_q    <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (ctl.accept) begin
				idx_q    <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
				if (cmd.action == tpool_pkg::ACT_TICK) begin
					now_q <= now_q + 32'd1;
				end
			end
			case (ctl.op)
				tpool_pkg::OP_TICK_EV: begin
					idx_q <= idx_q + 1'b1;
					if (fire && !per_q[idx_q]) begin
						run_q[idx_q] <= 1'b0;
					end
					if (fire && room) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
					end
				end
				tpool_pkg::OP_CREATE: begin
					if (!to_zero && alloc) begin
						used_q[idx_q] <= 1'b1;
						run_q[idx_q]  <= 1'b0;
						per_q[idx_q]  <= cmd_q.periodic;
					end else if (!to_zero && idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				tpool_pkg::OP_EXEC: begin
					if (exec_ok) begin
						case (cmd_q.action)
							tpool_pkg::ACT_DESTROY: begin
								used_q[hidx] <= 1'b0;
								run_q[hidx]  <= 1'b0;
								per_q[hidx]  <= 1'b0;
							end
							tpool_pkg::ACT_START:    run_q[hidx] <= 1'b1;
							tpool_pkg::ACT_STOP:     run_q[hidx] <= 1'b0;
							tpool_pkg::ACT_SET_TYPE: per_q[hidx] <= cmd_q.periodic;
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd;
		end
		if (ctl.op == tpool_pkg::OP_TICK_EV && fire && room) begin
			pend_h_q <= 4'(idx_q);
		end
		if (ctl.op == tpool_pkg::OP_QRY_EL) begin
			el_q <= qry_el;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

	`TPOOL_ASSERT_NEXT(a_tick_now, ctl.accept && cmd.action == tpool_pkg::ACT_TICK, now_q == $past(now_q) + 32'd1)
	`TPOOL_ASSERT_IMPL(a_pend_count, pend_v_q, n_q != '0)
	`TPOOL_ASSERT_NEXT(a_alloc_used, ctl.op == tpool_pkg::OP_CREATE && !to_zero && alloc, used_q[idx_q])

endmodule

// File: design/timer_pool_one_shot_periodic_core.sv
// ---------------------------------------------------------------------------
// Timer pool core
// Pool of timer slots, one-shot or periodic, sharing one tick counter.
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; the
// command travels on cmd. Results leave on result, each valid for exactly one
// cycle while strobe is high; the receiver cannot stall them.
// A tick sweeps the slots one per cycle out of the slot RAMs: it holds busy
// through a read step, the sweep and an end step, and its results, one per
// fired slot (at most 16) or one empty result, follow during the sweep and
// from its end step. Create scans the free flags one slot per cycle. Query
// steps through exec, elapsed and output states, for the registered RAM read
// and the elapsed and remaining subtractions. The other commands finish in
// the exec step. Each result appears on the ports in the cycle after the step
// that produces it, and the final result of a transaction carries last.
// Reset clears the tick counter and all slot flags, so every slot is free;
// the slot RAMs need no clearing since create writes all slot values.
// ---------------------------------------------------------------------------
module timer_pool_one_shot_periodic_core #(
	parameter int SLOTS = tpool_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tpool_pkg::cmd_t    cmd,
	output tpool_pkg::result_t result,
	output logic               strobe
);

	tpool_pkg::ctl_t ctl;
	tpool_pkg::sts_t sts;

	tpool_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (cmd.action),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	tpool_dp #(.SLOTS(SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule
